>>> rtl/pttc_pkg.sv
// ----------------------------------------------------------------------------
// pttc_pkg
// Shared widths and types for the pressure/temperature trim compensation.
// ----------------------------------------------------------------------------
package pttc_pkg;

    // Dividend/quotient width and divisor magnitude width of the divider
    localparam int DVD_W      = 64;
    localparam int DVS_W      = 31;
    localparam int DIV_STAGES = DVD_W;
    localparam int TC_W       = 24;

    // Side data that rides along with a transaction through the divider
    typedef struct packed {
        logic [TC_W-1:0] tc;
        logic            neg;
        logic            zero;
    } div_side_t;

endpackage

>>> rtl/pressure_temp_trim_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temp_trim_compensation
// Barometer trim compensation: 32-bit fine temperature, 64-bit pressure.
// ----------------------------------------------------------------------------
// Depth: 13 polynomial stages, 64 divider stages, 6 post-divide stages and the
//   output register lie between the accepting edge and out_valid.
// Throughput: one transaction per cycle while the skid entry is empty; the 64-stage divider sets the depth.
// A two-entry output (register plus skid) keeps in_ready registered.
// Reset: rst_n clears valid bits and all trim registers to zero.
module pressure_temp_trim_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [19:0] raw_pressure,
    input  logic [19:0] raw_temperature,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [23:0] temperature_centi,
    output logic [23:0] pressure_pa,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import pttc_pkg::*;

    localparam logic [1:0] REG_TEMP_TRIM = 2'd0;
    localparam logic [1:0] REG_PRESS_A   = 2'd1;
    localparam logic [1:0] REG_PRESS_B   = 2'd2;
    localparam logic [1:0] REG_PRESS_C   = 2'd3;

    // Low 64 bits of a 32-bit unsigned word times a 17-bit signed value
    function automatic logic [63:0] mul_lo(input logic [31:0] a,
                                           input logic signed [16:0] b);
        logic signed [49:0] pr;
        pr = $signed({1'b0, a}) * b;
        return {{14{pr[49]}}, pr};
    endfunction

    // Low 32 bits of a 32-bit word times a sign-extended 17-bit value
    function automatic logic [31:0] mul_hi(input logic [31:0] a,
                                           input logic signed [16:0] b);
        logic [31:0] bx;
        logic [63:0] pr;
        bx = {{15{b[16]}}, b};
        pr = a * bx;
        return pr[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0] temp_trim_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] press_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg <= '0;
            press_a_reg   <= '0;
            press_b_reg   <= '0;
            press_c_reg   <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:3])
                REG_TEMP_TRIM: temp_trim_reg <= pwdata[47:0];
                REG_PRESS_A:   press_a_reg   <= pwdata;
                REG_PRESS_B:   press_b_reg   <= pwdata;
                REG_PRESS_C:   press_c_reg   <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_TEMP_TRIM: prdata = {16'h0, temp_trim_reg};
            REG_PRESS_A:   prdata = press_a_reg;
            REG_PRESS_B:   prdata = press_b_reg;
            REG_PRESS_C:   prdata = {48'h0, press_c_reg};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Trim fields
    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = temp_trim_reg[15:0];
    assign t2 = $signed(temp_trim_reg[31:16]);
    assign t3 = $signed(temp_trim_reg[47:32]);
    assign p1 = press_a_reg[15:0];
    assign p2 = $signed(press_a_reg[31:16]);
    assign p3 = $signed(press_a_reg[47:32]);
    assign p4 = $signed(press_a_reg[63:48]);
    assign p5 = $signed(press_b_reg[15:0]);
    assign p6 = $signed(press_b_reg[31:16]);
    assign p7 = $signed(press_b_reg[47:32]);
    assign p8 = $signed(press_b_reg[63:48]);
    assign p9 = $signed(press_c_reg);

    // ------------------------------------------------------------------
    // Flow control: whole pipe moves unless the skid entry is occupied
    // ------------------------------------------------------------------
    logic        en;
    logic        skid_vld_reg;
    logic        out_vld_reg;
    logic [12:0] pre_vld_reg;
    logic [5:0]  post_vld_reg;

    assign en       = ~skid_vld_reg;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Temperature path (32-bit wrapping)
    // ------------------------------------------------------------------
    logic signed [17:0] s1_d1_reg;
    logic signed [16:0] s1_d2_reg;
    logic [19:0]        s1_adcp_reg, s2_adcp_reg, s3_adcp_reg, s4_adcp_reg;
    logic [19:0]        s5_adcp_reg, s6_adcp_reg, s7_adcp_reg, s8_adcp_reg;
    logic [19:0]        s9_adcp_reg;
    logic [31:0]        s2_ta_reg, s2_dd_reg, s3_tb_reg;
    logic signed [31:0] s3_a_reg, s4_fine_reg;
    logic [23:0]        s5_tc_reg, s6_tc_reg, s7_tc_reg, s8_tc_reg, s9_tc_reg;
    logic [23:0]        s10_tc_reg, s11_tc_reg, s12_tc_reg;
    logic signed [32:0] s5_v1_reg;

    logic signed [17:0] d1_c;
    logic signed [16:0] d2_c;
    logic signed [33:0] ta_full, dd_full;
    logic signed [31:0] a_c, ddsh_c, tbsh_c, fine_c, tcw_c;
    logic signed [47:0] tb_full;
    logic [31:0]        fine5_c;
    logic signed [32:0] v1_c;

    assign d1_c    = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign d2_c    = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign ta_full = s1_d1_reg * t2;
    assign dd_full = s1_d2_reg * s1_d2_reg;
    assign a_c     = $signed(s2_ta_reg) >>> 11;
    assign ddsh_c  = $signed(s2_dd_reg) >>> 12;
    assign tb_full = ddsh_c * t3;
    assign tbsh_c  = $signed(s3_tb_reg) >>> 14;
    assign fine_c  = s3_a_reg + tbsh_c;
    assign fine5_c = {s4_fine_reg[29:0], 2'b00} + s4_fine_reg + 32'd128;
    assign tcw_c   = $signed(fine5_c) >>> 8;
    assign v1_c    = $signed({s4_fine_reg[31], s4_fine_reg}) - 33'sd128000;

    // ------------------------------------------------------------------
    // Pressure polynomial (64-bit wrapping)
    // ------------------------------------------------------------------
    logic [63:0]        s6_sq_reg, s6_m5_reg, s6_m2_reg;
    logic [63:0]        s7_lo6_reg, s7_lo3_reg, s7_m5_reg, s7_m2_reg;
    logic [31:0]        s7_hi6_reg, s7_hi3_reg;
    logic [63:0]        s8_a6_reg, s8_a3_reg, s8_m5_reg, s8_m2_reg;
    logic [63:0]        s9_v2_reg, s9_vb_reg;
    logic [63:0]        s10_s_reg, s10_x_reg;
    logic [63:0]        s11_flo_reg, s11_nlo_reg;
    logic [31:0]        s11_fhi_reg, s11_nhi_reg;
    logic signed [30:0] s12_var1_reg;
    logic [63:0]        s12_num_reg;
    logic [DVD_W-1:0]   s13_ma_reg;
    logic [DVS_W-1:0]   s13_mb_reg;
    div_side_t          s13_side_reg;

    logic signed [65:0] sq_full;
    logic signed [48:0] m5_full, m2_full;
    logic [63:0]        p4x, v2_c, vb_c, s_c, praw_c, x_c, f_c, num_c;
    logic signed [63:0] a3sh_c;

    assign sq_full = s5_v1_reg * s5_v1_reg;
    assign m5_full = s5_v1_reg * p5;
    assign m2_full = s5_v1_reg * p2;
    assign p4x     = {{48{p4[15]}}, p4};
    assign v2_c    = s8_a6_reg + (s8_m5_reg << 17) + (p4x << 35);
    assign a3sh_c  = $signed(s8_a3_reg) >>> 8;
    assign vb_c    = a3sh_c + (s8_m2_reg << 12);
    assign s_c     = 64'h0000_8000_0000_0000 + s9_vb_reg;
    assign praw_c  = 64'd1048576 - {44'd0, s9_adcp_reg};
    assign x_c     = (praw_c << 31) - s9_v2_reg;
    assign f_c     = s11_flo_reg + {s11_fhi_reg, 32'h0};
    assign num_c   = s11_nlo_reg + {s11_nhi_reg, 32'h0};

    // Pre-divide valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
        end
        else if (en)
        begin
            pre_vld_reg <= {pre_vld_reg[11:0], in_valid};
        end
    end

    // Pre-divide payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // differences of raw temperature and trims
            s1_d1_reg   <= d1_c;
            s1_d2_reg   <= d2_c;
            s1_adcp_reg <= raw_pressure;
            // first products
            s2_ta_reg   <= ta_full[31:0];
            s2_dd_reg   <= dd_full[31:0];
            s2_adcp_reg <= s1_adcp_reg;
            // quadratic term product
            s3_a_reg    <= a_c;
            s3_tb_reg   <= tb_full[31:0];
            s3_adcp_reg <= s2_adcp_reg;
            // fine temperature
            s4_fine_reg <= fine_c;
            s4_adcp_reg <= s3_adcp_reg;
            // centi-degrees and pressure offset
            s5_tc_reg   <= tcw_c[23:0];
            s5_v1_reg   <= v1_c;
            s5_adcp_reg <= s4_adcp_reg;
            // square and linear products
            s6_sq_reg   <= sq_full[63:0];
            s6_m5_reg   <= {{15{m5_full[48]}}, m5_full};
            s6_m2_reg   <= {{15{m2_full[48]}}, m2_full};
            s6_tc_reg   <= s5_tc_reg;
            s6_adcp_reg <= s5_adcp_reg;
            // partial products of the square by P6 and P3
            s7_lo6_reg  <= mul_lo(s6_sq_reg[31:0], {p6[15], p6});
            s7_hi6_reg  <= mul_hi(s6_sq_reg[63:32], {p6[15], p6});
            s7_lo3_reg  <= mul_lo(s6_sq_reg[31:0], {p3[15], p3});
            s7_hi3_reg  <= mul_hi(s6_sq_reg[63:32], {p3[15], p3});
            s7_m5_reg   <= s6_m5_reg;
            s7_m2_reg   <= s6_m2_reg;
            s7_tc_reg   <= s6_tc_reg;
            s7_adcp_reg <= s6_adcp_reg;
            // assemble partial products
            s8_a6_reg   <= s7_lo6_reg + {s7_hi6_reg, 32'h0};
            s8_a3_reg   <= s7_lo3_reg + {s7_hi3_reg, 32'h0};
            s8_m5_reg   <= s7_m5_reg;
            s8_m2_reg   <= s7_m2_reg;
            s8_tc_reg   <= s7_tc_reg;
            s8_adcp_reg <= s7_adcp_reg;
            // var2 and var1 sums
            s9_v2_reg   <= v2_c;
            s9_vb_reg   <= vb_c;
            s9_tc_reg   <= s8_tc_reg;
            s9_adcp_reg <= s8_adcp_reg;
            // offset var1, dividend before scaling
            s10_s_reg   <= s_c;
            s10_x_reg   <= x_c;
            s10_tc_reg  <= s9_tc_reg;
            // partial products by P1 and by 3125
            s11_flo_reg <= mul_lo(s10_s_reg[31:0], {1'b0, p1});
            s11_fhi_reg <= mul_hi(s10_s_reg[63:32], {1'b0, p1});
            s11_nlo_reg <= mul_lo(s10_x_reg[31:0], 17'sd3125);
            s11_nhi_reg <= mul_hi(s10_x_reg[63:32], 17'sd3125);
            s11_tc_reg  <= s10_tc_reg;
            // divisor and dividend
            s12_var1_reg <= $signed(f_c[63:33]);
            s12_num_reg  <= num_c;
            s12_tc_reg   <= s11_tc_reg;
            // magnitudes and signs for the divider
            s13_ma_reg        <= s12_num_reg[63] ? (64'd0 - s12_num_reg) : s12_num_reg;
            s13_mb_reg        <= s12_var1_reg[30] ? (31'd0 - s12_var1_reg)
                                                  : s12_var1_reg;
            s13_side_reg.tc   <= s12_tc_reg;
            s13_side_reg.neg  <= s12_num_reg[63] ^ s12_var1_reg[30];
            s13_side_reg.zero <= (s12_var1_reg == 31'sd0);
        end
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    logic             div_vld;
    logic [DVD_W-1:0] div_q;
    div_side_t        div_side;

    pttc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (pre_vld_reg[12]),
        .in_ma    (s13_ma_reg),
        .in_mb    (s13_mb_reg),
        .in_side  (s13_side_reg),
        .out_vld  (div_vld),
        .out_q    (div_q),
        .out_side (div_side)
    );

    // ------------------------------------------------------------------
    // Post-divide correction terms
    // ------------------------------------------------------------------
    logic [63:0] q1_q_reg, q2_q_reg, q3_q_reg, q4_q_reg, q5_q_reg;
    logic [63:0] q2_ll_reg, q2_q8lo_reg, q3_phsq_reg, q3_w2_reg, q4_w2_reg;
    logic [63:0] q4_lo9_reg, q5_w1_reg, q5_w2_reg, q6_r_reg;
    logic [31:0] q2_cr_reg, q2_q8hi_reg, q4_hi9_reg;
    div_side_t   q1_side_reg, q2_side_reg, q3_side_reg, q4_side_reg;
    div_side_t   q5_side_reg, q6_side_reg;

    logic signed [63:0] ph_c, w2_c, w1_c;
    logic [63:0]        ll_c, cr_full, w2raw_c, w1raw_c;
    logic [31:0]        pa_sum_c;
    logic [23:0]        pa_c;

    assign ph_c     = $signed(q1_q_reg) >>> 13;
    assign ll_c     = ph_c[31:0] * ph_c[31:0];
    assign cr_full  = ph_c[31:0] * ph_c[63:32];
    assign w2raw_c  = q2_q8lo_reg + {q2_q8hi_reg, 32'h0};
    assign w2_c     = $signed(w2raw_c) >>> 19;
    assign w1raw_c  = q4_lo9_reg + {q4_hi9_reg, 32'h0};
    assign w1_c     = $signed(w1raw_c) >>> 25;
    assign pa_sum_c = q6_r_reg[39:8] + {{12{p7[15]}}, p7, 4'h0};
    assign pa_c     = q6_side_reg.zero ? 24'd0 : pa_sum_c[31:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_vld_reg <= '0;
        end
        else if (en)
        begin
            post_vld_reg <= {post_vld_reg[4:0], div_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // signed quotient
            q1_q_reg    <= div_side.neg ? (64'd0 - div_q) : div_q;
            q1_side_reg <= div_side;
            // square of p>>13 and P8 products
            q2_ll_reg   <= ll_c;
            q2_cr_reg   <= cr_full[31:0];
            q2_q8lo_reg <= mul_lo(q1_q_reg[31:0], {p8[15], p8});
            q2_q8hi_reg <= mul_hi(q1_q_reg[63:32], {p8[15], p8});
            q2_q_reg    <= q1_q_reg;
            q2_side_reg <= q1_side_reg;
            // assemble square, var2 term
            q3_phsq_reg <= q2_ll_reg + {q2_cr_reg[30:0], 1'b0, 32'h0};
            q3_w2_reg   <= w2_c;
            q3_q_reg    <= q2_q_reg;
            q3_side_reg <= q2_side_reg;
            // P9 partial products
            q4_lo9_reg  <= mul_lo(q3_phsq_reg[31:0], {p9[15], p9});
            q4_hi9_reg  <= mul_hi(q3_phsq_reg[63:32], {p9[15], p9});
            q4_w2_reg   <= q3_w2_reg;
            q4_q_reg    <= q3_q_reg;
            q4_side_reg <= q3_side_reg;
            // var1 term
            q5_w1_reg   <= w1_c;
            q5_w2_reg   <= q4_w2_reg;
            q5_q_reg    <= q4_q_reg;
            q5_side_reg <= q4_side_reg;
            // corrected Q24.16 sum before P7 offset
            q6_r_reg    <= q5_q_reg + q5_w1_reg + q5_w2_reg;
            q6_side_reg <= q5_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    logic        fin_vld;
    logic [23:0] out_tc_reg, out_pa_reg, skid_tc_reg, skid_pa_reg;

    assign fin_vld = post_vld_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_vld_reg && !out_ready)
        begin
            if (en && fin_vld)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (skid_vld_reg)
        begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= fin_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_vld_reg && !out_ready)
        begin
            if (en)
            begin
                skid_tc_reg <= q6_side_reg.tc;
                skid_pa_reg <= pa_c;
            end
        end
        else if (skid_vld_reg)
        begin
            out_tc_reg <= skid_tc_reg;
            out_pa_reg <= skid_pa_reg;
        end
        else
        begin
            out_tc_reg <= q6_side_reg.tc;
            out_pa_reg <= pa_c;
        end
    end

    assign out_valid         = out_vld_reg;
    assign temperature_centi = $signed(out_tc_reg);
    assign pressure_pa       = out_pa_reg;

`ifndef ASSERT_OFF
    // skid entry is only filled behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry valid without output valid");

    // an accepted transaction enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> pre_vld_reg[0])
        else $error("accepted transaction not in first stage");

    // a parked transaction is not dropped while the output stalls
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_vld_reg && !out_ready) |=> skid_vld_reg)
        else $error("skid entry lost during stall");
`endif

endmodule

>>> rtl/pttc_div.sv
// ----------------------------------------------------------------------------
// pttc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pttc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [pttc_pkg::DVD_W-1:0]   in_ma,
    input  logic [pttc_pkg::DVS_W-1:0]   in_mb,
    input  pttc_pkg::div_side_t          in_side,
    output logic                         out_vld,
    output logic [pttc_pkg::DVD_W-1:0]   out_q,
    output pttc_pkg::div_side_t          out_side
);
    import pttc_pkg::*;

    logic [DIV_STAGES-1:0] vld_reg;
    logic [DVS_W-1:0]      rem_reg  [DIV_STAGES];
    logic [DVD_W-1:0]      dq_reg   [DIV_STAGES];
    logic [DVS_W-1:0]      mb_reg   [DIV_STAGES];
    div_side_t             side_reg [DIV_STAGES];

    logic [DVS_W-1:0]      src_rem  [DIV_STAGES];
    logic [DVD_W-1:0]      src_dq   [DIV_STAGES];
    logic [DVS_W-1:0]      src_mb   [DIV_STAGES];
    div_side_t             src_side [DIV_STAGES];
    logic [DVS_W-1:0]      rem_next [DIV_STAGES];
    logic [DVD_W-1:0]      dq_next  [DIV_STAGES];

    // Stage inputs: first stage from the ports, others from the stage before
    always_comb
    begin
        src_rem[0]  = '0;
        src_dq[0]   = in_ma;
        src_mb[0]   = in_mb;
        src_side[0] = in_side;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            src_rem[k]  = rem_reg[k-1];
            src_dq[k]   = dq_reg[k-1];
            src_mb[k]   = mb_reg[k-1];
            src_side[k] = side_reg[k-1];
        end
    end

    // One trial subtract per stage; dividend bits shift out, quotient bits in
    always_comb
    begin
        logic [DVS_W+1:0] diff;
        logic             ge;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            diff = {1'b0, src_rem[k], src_dq[k][DVD_W-1]} - {2'b00, src_mb[k]};
            ge   = ~diff[DVS_W+1];
            rem_next[k] = ge ? diff[DVS_W-1:0]
                             : {src_rem[k][DVS_W-2:0], src_dq[k][DVD_W-1]};
            dq_next[k]  = {src_dq[k][DVD_W-2:0], ge};
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_vld};
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                dq_reg[k]   <= dq_next[k];
                mb_reg[k]   <= src_mb[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_q    = dq_reg[DIV_STAGES-1];
    assign out_side = side_reg[DIV_STAGES-1];

endmodule
